FILE: hw/rtl/lbp_pkg.sv
// ----------------------------------------------------------------------------
// lbp_pkg
// Shared constants, types and codes of the 3x3 LBP histogram unit.
// ----------------------------------------------------------------------------
`default_nettype none

package lbp_pkg;

  localparam int MAX_ROWS   = 256;
  localparam int MAX_COLS   = 256;
  localparam int BIN_COUNT  = 256;

  localparam int SIZE_W     = 9;
  localparam int FUNC_W     = 2;
  localparam int PIX_W      = 8;
  localparam int BIN_W      = $clog2(BIN_COUNT);
  localparam int COUNT_W    = 17;
  localparam int COL_W      = $clog2(MAX_COLS);
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = SIZE_W;

  // command queue between front and back; depth is a power of two
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  localparam logic [COUNT_W-1:0] BIN_MAX    = '1;
  localparam logic [SIZE_W-1:0]  ROWS_RESET = 9'd125;
  localparam logic [SIZE_W-1:0]  COLS_RESET = 9'd94;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_ROWS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_COLS = 2'd1;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_PIXEL = 2'd0,
    FUNC_READ  = 2'd1,
    FUNC_CLEAR = 2'd2
  } lbp_func_e;

  typedef enum logic [1:0] {
    KIND_PIXEL,
    KIND_READ,
    KIND_CLEAR,
    KIND_NOP
  } lbp_kind_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PIX_RD,
    ST_INC_RD,
    ST_INC_WR,
    ST_FL_START,
    ST_FL_PRIME,
    ST_FL_CODE,
    ST_FL_WR,
    ST_EMIT
  } lbp_state_e;

  // classified item as handed from front to back
  typedef struct packed {
    lbp_kind_e         kind;
    logic [PIX_W-1:0]  pixel;
    logic [BIN_W-1:0]  bin;
    logic [COL_W-1:0]  col;
    logic [SIZE_W-1:0] cols;
    logic              r_ge1;
    logic              r_ge2;
    logic              c_zero;
    logic              c_last;
    logic              frame_last;
  } lbp_cmd_t;

  typedef struct packed {
    logic               rd_en;
    logic [BIN_W-1:0]   rd_addr;
    logic               wr_en;
    logic [BIN_W-1:0]   wr_addr;
    logic [COUNT_W-1:0] wr_data;
    logic               clr;
  } lbp_hist_req_t;

  // window[row][col], col 0 is the left column
  typedef logic [2:0][2:0][PIX_W-1:0] lbp_win_t;

endpackage

`default_nettype wire

FILE: hw/rtl/lbp_if.sv
// ----------------------------------------------------------------------------
// lbp_if
// Item, result and configuration channels of the LBP histogram unit.
// ----------------------------------------------------------------------------
`default_nettype none

interface lbp_item_if import lbp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [PIX_W-1:0]  pixel;
  logic [BIN_W-1:0]  bin_index;

  modport source (output valid, func, pixel, bin_index, input ready);
  modport sink   (input valid, func, pixel, bin_index, output ready);
endinterface

interface lbp_result_if import lbp_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] bin_count;
  logic               frame_done;

  modport source (output valid, bin_count, frame_done, input ready);
  modport sink   (input valid, bin_count, frame_done, output ready);
endinterface

interface lbp_cfg_if import lbp_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/lbp_front.sv
// ----------------------------------------------------------------------------
// lbp_front
// Takes item beats, tracks the raster position and classifies each item
// into a command for the back end. Holds the frame size registers.
// ----------------------------------------------------------------------------
`default_nettype none

module lbp_front import lbp_pkg::*; (
  input  wire          clk_i,
  input  wire          rst_ni,
  lbp_item_if.sink     item_i,
  lbp_cfg_if.sink      cfg_i,
  input  wire          fifo_full_i,
  output logic         push_o,
  output lbp_cmd_t     cmd_o
);

  logic [SIZE_W-1:0] rows_q, rows_d, cols_q, cols_d;
  logic [SIZE_W-1:0] row_q, row_d, col_q, col_d;
  logic [SIZE_W-1:0] rows, cols;
  logic [SIZE_W-1:0] row0, r, c, c_inc;
  logic              wrap0, last;

  assign cfg_i.ready  = 1'b1;
  assign item_i.ready = !fifo_full_i;
  assign push_o       = item_i.valid && !fifo_full_i;

  always_comb begin
    rows_d = rows_q;
    cols_d = cols_q;
    if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_FRAME_ROWS: rows_d = cfg_i.data;
        REG_FRAME_COLS: cols_d = cfg_i.data;
        default: ;
      endcase
    end
  end

  // clamp sizes: zero acts as one, oversize acts as the maximum
  always_comb begin
    if (rows_q == '0) begin
      rows = SIZE_W'(1);
    end else if (rows_q > SIZE_W'(MAX_ROWS)) begin
      rows = SIZE_W'(MAX_ROWS);
    end else begin
      rows = rows_q;
    end
    if (cols_q == '0) begin
      cols = SIZE_W'(1);
    end else if (cols_q > SIZE_W'(MAX_COLS)) begin
      cols = SIZE_W'(MAX_COLS);
    end else begin
      cols = cols_q;
    end
  end

  always_comb begin
    wrap0 = col_q >= cols;
    row0  = wrap0 ? row_q + SIZE_W'(1) : row_q;
    c     = wrap0 ? '0 : col_q;
    r     = (row0 >= rows) ? '0 : row0;
    last  = (r == rows - SIZE_W'(1)) && (c == cols - SIZE_W'(1));
    c_inc = c + SIZE_W'(1);

    row_d = row_q;
    col_d = col_q;
    if (push_o && item_i.func == FUNC_PIXEL) begin
      if (last) begin
        row_d = '0;
        col_d = '0;
      end else if (c_inc >= cols) begin
        row_d = r + SIZE_W'(1);
        col_d = '0;
      end else begin
        row_d = r;
        col_d = c_inc;
      end
    end
  end

  always_comb begin
    case (item_i.func)
      FUNC_PIXEL: cmd_o.kind = KIND_PIXEL;
      FUNC_READ:  cmd_o.kind = KIND_READ;
      FUNC_CLEAR: cmd_o.kind = KIND_CLEAR;
      default:    cmd_o.kind = KIND_NOP;
    endcase
    cmd_o.pixel      = item_i.pixel;
    cmd_o.bin        = item_i.bin_index;
    cmd_o.col        = c[COL_W-1:0];
    cmd_o.cols       = cols;
    cmd_o.r_ge1      = r != '0;
    cmd_o.r_ge2      = r >= SIZE_W'(2);
    cmd_o.c_zero     = c == '0;
    cmd_o.c_last     = c == cols - SIZE_W'(1);
    cmd_o.frame_last = last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= ROWS_RESET;
      cols_q <= COLS_RESET;
      row_q  <= '0;
      col_q  <= '0;
    end else begin
      rows_q <= rows_d;
      cols_q <= cols_d;
      row_q  <= row_d;
      col_q  <= col_d;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/lbp_fifo.sv
// ----------------------------------------------------------------------------
// lbp_fifo
// Short command queue that decouples the front from the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module lbp_fifo import lbp_pkg::*; (
  input  wire       clk_i,
  input  wire       rst_ni,
  input  wire       push_i,
  input  lbp_cmd_t  data_i,
  input  wire       pop_i,
  output logic      full_o,
  output logic      empty_o,
  output lbp_cmd_t  data_o
);

  lbp_cmd_t             mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [FIFO_AW:0]     count_q, count_d;
  logic                 do_push, do_pop;

  assign full_o  = count_q == (FIFO_AW + 1)'(FIFO_DEPTH);
  assign empty_o = count_q == '0;
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + FIFO_AW'(1) : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + FIFO_AW'(1) : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + (FIFO_AW + 1)'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - (FIFO_AW + 1)'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o))
    else $error("command pushed into full queue");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= (FIFO_AW + 1)'(FIFO_DEPTH))
    else $error("queue count beyond depth");

endmodule

`default_nettype wire

FILE: hw/rtl/lbp_hist.sv
// ----------------------------------------------------------------------------
// lbp_hist
// 256-bin histogram memory with per-bin valid bits; an invalid bin reads
// as zero, so a clear only resets the valid bits and writes no bin.
// ----------------------------------------------------------------------------
`default_nettype none

module lbp_hist import lbp_pkg::*; (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  lbp_hist_req_t       req_i,
  output logic [COUNT_W-1:0]  rd_count_o
);

  logic [COUNT_W-1:0]   mem_q [BIN_COUNT];
  logic [BIN_COUNT-1:0] vld_q;
  logic [COUNT_W-1:0]   rd_data_q;
  logic                 rd_vld_q;

  assign rd_count_o = rd_vld_q ? rd_data_q : '0;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rd_data_q <= mem_q[req_i.rd_addr];
      rd_vld_q  <= vld_q[req_i.rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (req_i.clr) begin
      vld_q <= '0;
    end else if (req_i.wr_en) begin
      vld_q[req_i.wr_addr] <= 1'b1;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/lbp_back.sv
// ----------------------------------------------------------------------------
// lbp_back
// Back-end sequencer: line stores, 3x3 window, LBP code generation,
// histogram read-modify-write, bottom-row flush and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module lbp_back import lbp_pkg::*; (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 fifo_empty_i,
  input  lbp_cmd_t            fifo_data_i,
  output logic                fifo_pop_o,
  output lbp_hist_req_t       hist_req_o,
  input  wire [COUNT_W-1:0]   hist_count_i,
  lbp_result_if.source        result_o
);

  function automatic lbp_win_t shift_col(lbp_win_t w, logic [PIX_W-1:0] t,
                                         logic [PIX_W-1:0] m, logic [PIX_W-1:0] b);
    lbp_win_t s;
    s = w;
    for (int i = 0; i < 3; i++) begin
      s[i][0] = w[i][1];
      s[i][1] = w[i][2];
    end
    s[0][2] = t;
    s[1][2] = m;
    s[2][2] = b;
    return s;
  endfunction

  function automatic logic [BIN_W-1:0] lbp_code(lbp_win_t w);
    logic [BIN_W-1:0] code;
    logic [PIX_W-1:0] c;
    c       = w[1][1];
    code[7] = c > w[0][0];
    code[6] = c > w[0][1];
    code[5] = c > w[0][2];
    code[4] = c > w[1][2];
    code[3] = c > w[2][2];
    code[2] = c > w[2][1];
    code[1] = c > w[2][0];
    code[0] = c > w[1][0];
    return code;
  endfunction

  lbp_state_e         state_q, state_d, after_codes;
  lbp_cmd_t           cmd_q, cmd_d;
  lbp_win_t           win_q, win_d;
  logic [BIN_W-1:0]   code_a_q, code_a_d, code_b_q, code_b_d;
  logic               two_q, two_d;
  logic [SIZE_W-1:0]  fl_k_q, fl_k_d, fl_k_p1, fl_k_p2;
  logic [PIX_W-1:0]   fl_tl_q, fl_tl_d, fl_tc_q, fl_tc_d;
  logic [PIX_W-1:0]   fl_ml_q, fl_ml_d, fl_mc_q, fl_mc_d;
  logic               out_valid_q, out_valid_d;
  logic [COUNT_W-1:0] bin_count_q, bin_count_d;
  logic               frame_done_q, frame_done_d;

  // line stores, reset contents undefined
  logic [PIX_W-1:0]   above_mem [MAX_COLS];
  logic [PIX_W-1:0]   two_mem [MAX_COLS];
  logic [PIX_W-1:0]   above_rd_q, two_rd_q;
  logic               line_rd_en, line_wr_en;
  logic [COL_W-1:0]   line_rd_addr;

  lbp_win_t           pix_base, pix_w1, pix_w2, fl_win;
  logic [PIX_W-1:0]   pix_t, pix_m, fl_tr, fl_mr;
  logic [BIN_W-1:0]   pix_code1, pix_code2, fl_code;
  logic               need1, need2, fl_has_right;
  logic [COUNT_W-1:0] sat_inc;

  assign result_o.valid      = out_valid_q;
  assign result_o.bin_count  = bin_count_q;
  assign result_o.frame_done = frame_done_q;

  // per-pixel window update, second shift closes the right edge
  always_comb begin
    pix_base  = cmd_q.c_zero ? '0 : win_q;
    pix_t     = cmd_q.r_ge2 ? two_rd_q : '0;
    pix_m     = cmd_q.r_ge1 ? above_rd_q : '0;
    pix_w1    = shift_col(pix_base, pix_t, pix_m, cmd_q.pixel);
    pix_w2    = shift_col(pix_w1, '0, '0, '0);
    pix_code1 = lbp_code(pix_w1);
    pix_code2 = lbp_code(pix_w2);
    need1     = cmd_q.r_ge1 && !cmd_q.c_zero;
    need2     = cmd_q.r_ge1 && cmd_q.c_last;
  end

  // bottom-row flush: sliding 2x3 window over both line stores
  always_comb begin
    fl_k_p1      = fl_k_q + SIZE_W'(1);
    fl_k_p2      = fl_k_q + SIZE_W'(2);
    fl_has_right = fl_k_p1 < cmd_q.cols;
    fl_tr        = (fl_has_right && cmd_q.r_ge1) ? two_rd_q : '0;
    fl_mr        = fl_has_right ? above_rd_q : '0;
    fl_win       = '0;
    fl_win[0][0] = fl_tl_q;
    fl_win[0][1] = fl_tc_q;
    fl_win[0][2] = fl_tr;
    fl_win[1][0] = fl_ml_q;
    fl_win[1][1] = fl_mc_q;
    fl_win[1][2] = fl_mr;
    fl_code      = lbp_code(fl_win);
  end

  assign sat_inc     = (hist_count_i == BIN_MAX) ? hist_count_i
                                                 : hist_count_i + COUNT_W'(1);
  assign after_codes = cmd_q.frame_last ? ST_FL_START : ST_EMIT;

  always_comb begin
    state_d      = state_q;
    cmd_d        = cmd_q;
    win_d        = win_q;
    code_a_d     = code_a_q;
    code_b_d     = code_b_q;
    two_d        = two_q;
    fl_k_d       = fl_k_q;
    fl_tl_d      = fl_tl_q;
    fl_tc_d      = fl_tc_q;
    fl_ml_d      = fl_ml_q;
    fl_mc_d      = fl_mc_q;
    out_valid_d  = out_valid_q;
    bin_count_d  = bin_count_q;
    frame_done_d = frame_done_q;
    hist_req_o   = '0;
    line_rd_en   = 1'b0;
    line_rd_addr = '0;
    line_wr_en   = 1'b0;
    fifo_pop_o   = 1'b0;

    if (out_valid_q && result_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (!fifo_empty_i) begin
          fifo_pop_o = 1'b1;
          cmd_d      = fifo_data_i;
          case (fifo_data_i.kind)
            KIND_PIXEL: begin
              line_rd_en   = 1'b1;
              line_rd_addr = fifo_data_i.col;
              state_d      = ST_PIX_RD;
            end
            KIND_READ: begin
              hist_req_o.rd_en   = 1'b1;
              hist_req_o.rd_addr = fifo_data_i.bin;
              state_d            = ST_EMIT;
            end
            KIND_CLEAR: begin
              hist_req_o.clr = 1'b1;
              state_d        = ST_EMIT;
            end
            default: state_d = ST_EMIT;
          endcase
        end
      end
      ST_PIX_RD: begin
        line_wr_en = 1'b1;
        win_d      = need2 ? pix_w2 : pix_w1;
        code_b_d   = pix_code2;
        if (need1) begin
          code_a_d = pix_code1;
          two_d    = need2;
          state_d  = ST_INC_RD;
        end else if (need2) begin
          code_a_d = pix_code2;
          two_d    = 1'b0;
          state_d  = ST_INC_RD;
        end else begin
          state_d = after_codes;
        end
      end
      ST_INC_RD: begin
        hist_req_o.rd_en   = 1'b1;
        hist_req_o.rd_addr = code_a_q;
        state_d            = ST_INC_WR;
      end
      ST_INC_WR: begin
        hist_req_o.wr_en   = 1'b1;
        hist_req_o.wr_addr = code_a_q;
        hist_req_o.wr_data = sat_inc;
        if (two_q) begin
          code_a_d = code_b_q;
          two_d    = 1'b0;
          state_d  = ST_INC_RD;
        end else begin
          state_d = after_codes;
        end
      end
      ST_FL_START: begin
        line_rd_en   = 1'b1;
        line_rd_addr = '0;
        win_d        = '0;
        state_d      = ST_FL_PRIME;
      end
      ST_FL_PRIME: begin
        fl_tl_d      = '0;
        fl_ml_d      = '0;
        fl_tc_d      = cmd_q.r_ge1 ? two_rd_q : '0;
        fl_mc_d      = above_rd_q;
        fl_k_d       = '0;
        line_rd_en   = 1'b1;
        line_rd_addr = COL_W'(1);
        state_d      = ST_FL_CODE;
      end
      ST_FL_CODE: begin
        hist_req_o.rd_en   = 1'b1;
        hist_req_o.rd_addr = fl_code;
        code_a_d           = fl_code;
        fl_tl_d            = fl_tc_q;
        fl_tc_d            = fl_tr;
        fl_ml_d            = fl_mc_q;
        fl_mc_d            = fl_mr;
        line_rd_en         = 1'b1;
        line_rd_addr       = fl_k_p2[COL_W-1:0];
        state_d            = ST_FL_WR;
      end
      ST_FL_WR: begin
        hist_req_o.wr_en   = 1'b1;
        hist_req_o.wr_addr = code_a_q;
        hist_req_o.wr_data = sat_inc;
        fl_k_d             = fl_k_p1;
        state_d            = (fl_k_p1 >= cmd_q.cols) ? ST_EMIT : ST_FL_CODE;
      end
      ST_EMIT: begin
        if (!out_valid_q || result_o.ready) begin
          out_valid_d  = 1'b1;
          bin_count_d  = (cmd_q.kind == KIND_READ) ? hist_count_i : '0;
          frame_done_d = (cmd_q.kind == KIND_PIXEL) && cmd_q.frame_last;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (line_wr_en) begin
      above_mem[cmd_q.col] <= cmd_q.pixel;
      two_mem[cmd_q.col]   <= above_rd_q;
    end
    if (line_rd_en) begin
      above_rd_q <= above_mem[line_rd_addr];
      two_rd_q   <= two_mem[line_rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q        <= cmd_d;
    code_a_q     <= code_a_d;
    code_b_q     <= code_b_d;
    fl_k_q       <= fl_k_d;
    fl_tl_q      <= fl_tl_d;
    fl_tc_q      <= fl_tc_d;
    fl_ml_q      <= fl_ml_d;
    fl_mc_q      <= fl_mc_d;
    bin_count_q  <= bin_count_d;
    frame_done_q <= frame_done_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      win_q       <= '0;
      two_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      win_q       <= win_d;
      two_q       <= two_d;
      out_valid_q <= out_valid_d;
    end
  end

  a_hist_one_port: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(hist_req_o.rd_en && hist_req_o.wr_en))
    else $error("histogram read and write in the same cycle");

  a_inc_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_INC_WR) |-> ($past(state_q) == ST_INC_RD))
    else $error("histogram write without preceding read");

  a_flush_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FL_CODE) |-> (fl_k_q < cmd_q.cols))
    else $error("flush column beyond frame width");

  a_flush_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FL_WR) |=> (state_q == ST_FL_CODE || state_q == ST_EMIT))
    else $error("flush left through an unexpected state");

endmodule

`default_nettype wire

FILE: hw/rtl/lbp_histogram_3x3_unit.sv
// Each item passes the front, the command queue and the back-end sequencer to a
// registered result beat; a pixel also does a histogram read-modify-write per code it
// counts (0 to 2), and the last pixel of a frame adds the bottom-row flush.
// The single back-end sequencer and the one-port histogram read-modify-write take a new
// item only when done with the last one (flush included); a 4-deep queue takes bursts.
// Reset: histogram reads as all zero, window and raster position cleared, frame size
// 125 x 94; line stores are not cleared and no clearing pass runs.
// ----------------------------------------------------------------------------
// lbp_histogram_3x3_unit
// Streaming 3x3 local binary pattern histogram: front classifier, command
// queue, back-end sequencer and histogram memory.
// ----------------------------------------------------------------------------
`default_nettype none

module lbp_histogram_3x3_unit import lbp_pkg::*; (
  input  wire            clk_i,
  input  wire            rst_ni,
  lbp_item_if.sink       item_i,
  lbp_cfg_if.sink        cfg_i,
  lbp_result_if.source   result_o
);

  logic               fifo_full, fifo_empty, fifo_push, fifo_pop;
  lbp_cmd_t           front_cmd, fifo_cmd;
  lbp_hist_req_t      hist_req;
  logic [COUNT_W-1:0] hist_count;

  lbp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (item_i),
    .cfg_i       (cfg_i),
    .fifo_full_i (fifo_full),
    .push_o      (fifo_push),
    .cmd_o       (front_cmd)
  );

  lbp_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fifo_push),
    .data_i  (front_cmd),
    .pop_i   (fifo_pop),
    .full_o  (fifo_full),
    .empty_o (fifo_empty),
    .data_o  (fifo_cmd)
  );

  lbp_hist u_hist (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (hist_req),
    .rd_count_o (hist_count)
  );

  lbp_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fifo_empty_i (fifo_empty),
    .fifo_data_i  (fifo_cmd),
    .fifo_pop_o   (fifo_pop),
    .hist_req_o   (hist_req),
    .hist_count_i (hist_count),
    .result_o     (result_o)
  );

endmodule

`default_nettype wire

FILE: sim/lbp_histogram_check.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lbp_histogram_check
// Watches the item, configuration and result channels of the LBP histogram
// unit, keeps its own copy of line stores, window and bins, and compares
// every result beat with the oldest predicted one.
// ----------------------------------------------------------------------------
module lbp_histogram_check import lbp_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  lbp_item_if   item_mon,
  lbp_cfg_if    cfg_mon,
  lbp_result_if result_mon,
  output int    fail_count_o,
  output int    pending_o
);

  typedef struct packed {
    logic [COUNT_W-1:0] bin_count;
    logic               frame_done;
  } bin_result_t;

  logic [SIZE_W-1:0]  rows_cfg;
  logic [SIZE_W-1:0]  cols_cfg;
  logic [PIX_W-1:0]   above_line     [MAX_COLS];
  logic [PIX_W-1:0]   two_above_line [MAX_COLS];
  lbp_win_t           win;
  int unsigned        row_pos;
  int unsigned        col_pos;
  logic [COUNT_W-1:0] hist [BIN_COUNT];
  bin_result_t        expected_results [$];

  function automatic int unsigned frame_size(logic [SIZE_W-1:0] v, int unsigned limit);
    if (v == 0) return 1;
    if (v > limit) return limit;
    return v;
  endfunction

  function automatic lbp_win_t slide_in(lbp_win_t w, logic [PIX_W-1:0] t,
                                        logic [PIX_W-1:0] m, logic [PIX_W-1:0] b);
    lbp_win_t s;
    s = w;
    for (int i = 0; i < 3; i++) begin
      s[i][0] = w[i][1];
      s[i][1] = w[i][2];
    end
    s[0][2] = t;
    s[1][2] = m;
    s[2][2] = b;
    return s;
  endfunction

  // bit set when the center is strictly above the neighbor, clockwise from top-left
  function automatic void tally_code(lbp_win_t w);
    logic [PIX_W-1:0] ctr;
    logic [BIN_W-1:0] code;
    ctr  = w[1][1];
    code = {ctr > w[0][0], ctr > w[0][1], ctr > w[0][2], ctr > w[1][2],
            ctr > w[2][2], ctr > w[2][1], ctr > w[2][0], ctr > w[1][0]};
    if (hist[code] != BIN_MAX) hist[code] = hist[code] + 1'b1;
  endfunction

  function automatic bin_result_t predict_item(logic [FUNC_W-1:0] func,
                                               logic [PIX_W-1:0] pixel,
                                               logic [BIN_W-1:0] bin);
    bin_result_t      res;
    int unsigned      rows;
    int unsigned      cols;
    int unsigned      r;
    int unsigned      c;
    int unsigned      x;
    logic [PIX_W-1:0] top_px;
    logic [PIX_W-1:0] mid_px;
    lbp_win_t         fw;
    res  = '0;
    rows = frame_size(rows_cfg, MAX_ROWS);
    cols = frame_size(cols_cfg, MAX_COLS);
    case (func)
      FUNC_READ: begin
        res.bin_count = hist[bin];
      end
      FUNC_CLEAR: begin
        for (int i = 0; i < BIN_COUNT; i++) hist[i] = '0;
      end
      FUNC_PIXEL: begin
        if (col_pos >= cols) begin
          col_pos = 0;
          row_pos++;
        end
        if (row_pos >= rows) row_pos = 0;
        r = row_pos;
        c = col_pos;
        if (c == 0) win = '0;
        top_px = (r >= 2) ? two_above_line[c] : '0;
        mid_px = (r >= 1) ? above_line[c] : '0;
        two_above_line[c] = above_line[c];
        above_line[c]     = pixel;
        win = slide_in(win, top_px, mid_px, pixel);
        if (r >= 1 && c >= 1) tally_code(win);
        // right column: its code is closed with out-of-frame zeros
        if (r >= 1 && c == cols - 1) begin
          win = slide_in(win, '0, '0, '0);
          tally_code(win);
        end
        if (r == rows - 1 && c == cols - 1) begin
          // bottom row centers, nothing below them
          for (int k = 0; k < cols; k++) begin
            fw = '0;
            for (int j = 0; j < 3; j++) begin
              x = k + j;
              if (x != 0 && x <= cols) begin
                if (r >= 1) fw[0][j] = two_above_line[x - 1];
                fw[1][j] = above_line[x - 1];
              end
            end
            tally_code(fw);
          end
          res.frame_done = 1'b1;
          row_pos = 0;
          col_pos = 0;
          win     = '0;
        end else begin
          col_pos = c + 1;
          if (col_pos >= cols) begin
            col_pos = 0;
            row_pos = r + 1;
          end
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    bin_result_t head;
    if (!rst_ni) begin
      rows_cfg = ROWS_RESET;
      cols_cfg = COLS_RESET;
      win      = '0;
      row_pos  = 0;
      col_pos  = 0;
      for (int i = 0; i < BIN_COUNT; i++) hist[i] = '0;
      for (int i = 0; i < MAX_COLS; i++) begin
        above_line[i]     = '0;
        two_above_line[i] = '0;
      end
      expected_results.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          REG_FRAME_ROWS: rows_cfg = cfg_mon.data;
          REG_FRAME_COLS: cols_cfg = cfg_mon.data;
          default: ;
        endcase
      end
      if (result_mon.valid && result_mon.ready) begin
        if (expected_results.size() == 0) begin
          fail_count_o++;
          $display("%0t: result beat with nothing expected: bin_count %0d frame_done %0b",
                   $time, result_mon.bin_count, result_mon.frame_done);
        end else begin
          head = expected_results.pop_front();
          if (result_mon.bin_count !== head.bin_count) begin
            fail_count_o++;
            $display("%0t: bin_count mismatch: expected %0d, actual %0d",
                     $time, head.bin_count, result_mon.bin_count);
          end
          if (result_mon.frame_done !== head.frame_done) begin
            fail_count_o++;
            $display("%0t: frame_done mismatch: expected %0b, actual %0b",
                     $time, head.frame_done, result_mon.frame_done);
          end
        end
      end
      if (item_mon.valid && item_mon.ready) begin
        expected_results.push_back(predict_item(item_mon.func, item_mon.pixel,
                                                item_mon.bin_index));
      end
      pending_o = expected_results.size();
    end
  end

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives frames of pixels with read, clear and unused items mixed in, across
// many frame sizes including a clamped full-width frame, with random gaps on
// both channels; the histogram check module predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_top;
  import lbp_pkg::*;

  localparam int CLK_PERIOD  = 8;
  localparam int CYCLE_LIMIT = 400000;
  // includes one full-width frame of about 256 pixels
  localparam int RANDOM_ITEMS = 480;

  localparam logic [FUNC_W-1:0]    FUNC_SPARE  = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  localparam logic [PIX_W-1:0] PROBE_FRAME [9] = '{
    8'd128, 8'd0,   8'd255,
    8'd128, 8'd128, 8'd127,
    8'd1,   8'd255, 8'd0
  };

  typedef enum int {TEX_NOISE, TEX_TIES, TEX_FLAT, TEX_BINARY} texture_e;

  logic clk_i;
  logic rst_ni;
  int   fail_count;
  int   pending;
  int   cycle_count = 0;
  int   sent_items  = 0;
  bit   gaps_on     = 1'b1;

  lbp_item_if   item_ch ();
  lbp_cfg_if    cfg_ch ();
  lbp_result_if result_ch ();

  lbp_histogram_3x3_unit DUT (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_ch),
    .cfg_i    (cfg_ch),
    .result_o (result_ch)
  );

  lbp_histogram_check histogram_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_mon     (item_ch),
    .cfg_mon      (cfg_ch),
    .result_mon   (result_ch),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic send_item(logic [FUNC_W-1:0] func, logic [PIX_W-1:0] pixel,
                           logic [BIN_W-1:0] bin);
    int gap;
    gap = gaps_on ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      @(negedge clk_i);
      item_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    item_ch.valid     <= 1'b1;
    item_ch.func      <= func;
    item_ch.pixel     <= pixel;
    item_ch.bin_index <= bin;
    do @(posedge clk_i); while (!item_ch.ready);
    sent_items++;
  endtask

  // lowers valid after the last beat, then holds until every result is back
  task automatic wait_drain();
    @(negedge clk_i);
    item_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    @(negedge clk_i);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk_i); while (!cfg_ch.ready);
    @(negedge clk_i);
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic int unsigned frame_pixels(logic [SIZE_W-1:0] rows_val,
                                               logic [SIZE_W-1:0] cols_val);
    int unsigned h;
    int unsigned w;
    h = (rows_val == 0) ? 1 : ((rows_val > MAX_ROWS) ? MAX_ROWS : rows_val);
    w = (cols_val == 0) ? 1 : ((cols_val > MAX_COLS) ? MAX_COLS : cols_val);
    return h * w;
  endfunction

  function automatic logic [PIX_W-1:0] draw_pixel(texture_e tex, logic [PIX_W-1:0] base);
    case (tex)
      TEX_NOISE: return PIX_W'($urandom_range(0, 255));
      TEX_TIES:  return base + PIX_W'($urandom_range(0, 3));
      TEX_FLAT:  return base;
      default:   return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
    endcase
  endfunction

  task automatic send_noise();
    int pick;
    pick = $urandom_range(0, 19);
    if (pick < 14) send_item(FUNC_READ, PIX_W'($urandom), BIN_W'($urandom));
    else if (pick < 16) send_item(FUNC_CLEAR, PIX_W'($urandom), BIN_W'($urandom));
    else send_item(FUNC_SPARE, PIX_W'($urandom), BIN_W'($urandom));
  endtask

  task automatic run_frame(logic [SIZE_W-1:0] rows_val, logic [SIZE_W-1:0] cols_val,
                           texture_e tex);
    int unsigned      n_px;
    logic [PIX_W-1:0] base;
    n_px = frame_pixels(rows_val, cols_val);
    case ($urandom_range(0, 3))
      0:       base = 8'd0;
      1:       base = 8'd252;
      default: base = PIX_W'($urandom_range(0, 252));
    endcase
    // sizes only change between frames, with the block drained
    wait_drain();
    write_reg(REG_FRAME_ROWS, rows_val);
    write_reg(REG_FRAME_COLS, cols_val);
    for (int unsigned p = 0; p < n_px; p++) begin
      if ($urandom_range(0, 9) == 0) send_noise();
      if ($urandom_range(0, 49) == 0) wait_drain();
      send_item(FUNC_PIXEL, draw_pixel(tex, base), BIN_W'($urandom));
    end
    repeat ($urandom_range(0, 3)) send_item(FUNC_READ, PIX_W'($urandom), BIN_W'($urandom));
  endtask

  initial begin : result_pacing
    int stall;
    result_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = gaps_on ? $urandom_range(0, 9) : 0;
      if (stall > 0) begin
        @(negedge clk_i);
        result_ch.ready <= 1'b0;
        repeat (stall - 1) @(negedge clk_i);
      end
      @(negedge clk_i);
      result_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!result_ch.valid);
    end
  end

  initial begin : stimulus
    int               frame_no;
    int               base_items;
    logic [SIZE_W-1:0] rows_val;
    logic [SIZE_W-1:0] cols_val;
    item_ch.valid     = 1'b0;
    item_ch.func      = FUNC_PIXEL;
    item_ch.pixel     = '0;
    item_ch.bin_index = '0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.index      = REG_FRAME_ROWS;
    cfg_ch.data       = '0;
    rst_ni            = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // bins read zero out of reset
    send_item(FUNC_READ, 8'h00, 8'h00);
    send_item(FUNC_READ, 8'hFF, 8'hFF);
    wait_drain();

    // zero sizes act as one; unused register indexes are ignored
    write_reg(REG_FRAME_ROWS, 9'd0);
    write_reg(REG_FRAME_COLS, 9'd0);
    write_reg(REG_SPARE_A, 9'h1FF);
    write_reg(REG_SPARE_B, 9'h155);
    send_item(FUNC_PIXEL, 8'hFF, 8'h00);
    send_item(FUNC_PIXEL, 8'h00, 8'hFF);
    send_item(FUNC_READ, 8'h00, 8'hFF);
    send_item(FUNC_READ, 8'hFF, 8'h00);
    send_item(FUNC_SPARE, 8'hAA, 8'h55);
    send_item(FUNC_CLEAR, 8'h55, 8'hAA);
    send_item(FUNC_READ, 8'h00, 8'hFF);
    wait_drain();

    write_reg(REG_FRAME_ROWS, 9'd3);
    write_reg(REG_FRAME_COLS, 9'd3);
    for (int i = 0; i < 9; i++) begin
      send_item(FUNC_PIXEL, PROBE_FRAME[i], 8'h00);
      if (i == 4) send_item(FUNC_READ, 8'h00, 8'h00);
      if (i == 5) wait_drain();
    end
    send_item(FUNC_READ, 8'h00, 8'h00);
    send_item(FUNC_READ, 8'h00, 8'hFF);
    send_item(FUNC_READ, 8'h00, 8'h80);

    frame_no   = 0;
    base_items = sent_items;
    while (sent_items - base_items < RANDOM_ITEMS) begin
      gaps_on = ($urandom_range(0, 3) != 0);
      if (frame_no == 2) begin
        // oversize width clamps to the full line
        run_frame(9'd1, 9'd511, TEX_NOISE);
      end else begin
        if ($urandom_range(0, 9) == 0) begin
          rows_val = SIZE_W'($urandom_range(8, 16));
          cols_val = SIZE_W'($urandom_range(8, 16));
        end else begin
          rows_val = SIZE_W'($urandom_range(0, 6));
          cols_val = SIZE_W'($urandom_range(0, 9));
        end
        run_frame(rows_val, cols_val, texture_e'($urandom_range(0, 3)));
      end
      frame_no++;
    end

    // sample every eighth bin at the end
    gaps_on = 1'b1;
    for (int b = 0; b < BIN_COUNT; b += 8) begin
      send_item(FUNC_READ, PIX_W'($urandom), BIN_W'(b));
    end

    wait_drain();
    repeat (40) @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/lbp_pkg.sv
hw/rtl/lbp_if.sv
hw/rtl/lbp_front.sv
hw/rtl/lbp_fifo.sv
hw/rtl/lbp_hist.sv
hw/rtl/lbp_back.sv
hw/rtl/lbp_histogram_3x3_unit.sv
sim/lbp_histogram_check.sv
sim/tb_top.sv
